/* design/point_set_box_sphere_distance_defines.svh */
// Assertion macros for the checker of this block.
`ifndef POINT_SET_BOX_SPHERE_DISTANCE_DEFINES_SVH
`define POINT_SET_BOX_SPHERE_DISTANCE_DEFINES_SVH

// Property checked only outside reset.
`define PSBSD_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PSBSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/psbsd_pkg.sv */
package psbsd_pkg;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int DIMS_W   = 2;
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam int SQ_W     = 2 * COORD_W;

    // dimensions register codes
    localparam logic [DIMS_W-1:0] DIMS_PLANAR = 2'd2;
    localparam logic [DIMS_W-1:0] DIMS_RESET  = 2'd3;

    // axis indexes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 2;

    // first trial bit of the square root (bit 62)
    localparam logic [SQ_W-1:0] ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);

    // largest Q16.16 value, at the width of the distance difference
    localparam logic signed [COORD_W+1:0] DIST_LIMIT = 34'sh0_7FFF_FFFF;
    localparam logic [COORD_W-1:0]        DIST_SAT   = 32'h7FFF_FFFF;

    typedef logic [COORD_W-1:0] coord_t;

    // one finished set, handed from the front to the back
    typedef struct packed {
        coord_t [AXES-1:0]   lo;
        coord_t [AXES-1:0]   hi;
        coord_t [AXES-1:0]   ctr;
        logic [RADIUS_W-1:0] radius;
        logic                planar;
    } psbsd_job_t;

    // queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } psbsd_q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GAP,
        BK_MUL,
        BK_ACC,
        BK_ROOT,
        BK_FIN
    } psbsd_bk_state_t;

endpackage

/* design/psbsd_front.sv */
module psbsd_front
    import psbsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  coord_t              s_point_x,
    input  coord_t              s_point_y,
    input  coord_t              s_point_z,
    input  coord_t              s_center_x,
    input  coord_t              s_center_y,
    input  coord_t              s_center_z,
    input  logic [RADIUS_W-1:0] s_radius,
    input  logic                s_last,
    input  logic                cfg_wr_en,
    input  logic [DIMS_W-1:0]   cfg_wr_data,
    input  psbsd_q_status_t     q_status,
    output logic                push,
    output psbsd_job_t          push_job
);

    coord_t            pt [AXES];
    coord_t            lo_reg [AXES];
    coord_t            hi_reg [AXES];
    coord_t            lo_next [AXES];
    coord_t            hi_next [AXES];
    logic              empty_reg;
    logic [DIMS_W-1:0] dims_reg;
    logic              accept;

    assign pt[AXIS_X] = s_point_x;
    assign pt[AXIS_Y] = s_point_y;
    assign pt[AXIS_Z] = s_point_z;

    // points are taken while the set queue has room
    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && s_last;

    // running box including the current point
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            lo_next[i] = (empty_reg || ($signed(pt[i]) < $signed(lo_reg[i]))) ? pt[i] : lo_reg[i];
            hi_next[i] = (empty_reg || ($signed(pt[i]) > $signed(hi_reg[i]))) ? pt[i] : hi_reg[i];
        end
    end

    // finished set for the back end
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            push_job.lo[i] = lo_next[i];
            push_job.hi[i] = hi_next[i];
        end
        push_job.ctr[AXIS_X] = s_center_x;
        push_job.ctr[AXIS_Y] = s_center_y;
        push_job.ctr[AXIS_Z] = s_center_z;
        push_job.radius      = s_radius;
        push_job.planar      = (dims_reg == DIMS_PLANAR);
    end

    // control: set-empty flag and mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_reg <= 1'b1;
            dims_reg  <= DIMS_RESET;
        end else begin
            if (cfg_wr_en) begin
                dims_reg <= cfg_wr_data;
            end
            if (accept) begin
                empty_reg <= s_last;
            end
        end
    end

    // box corners
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < AXES; i++) begin
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
            end
        end
    end

endmodule

/* design/psbsd_queue.sv */
module psbsd_queue
    import psbsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  psbsd_job_t      push_job,
    input  logic            pop,
    output psbsd_job_t      head,
    output psbsd_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psbsd_job_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* design/psbsd_back.sv */
module psbsd_back
    import psbsd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  psbsd_job_t      head,
    input  psbsd_q_status_t q_status,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output coord_t          m_distance,
    output coord_t          m_box_min_x,
    output coord_t          m_box_min_y,
    output coord_t          m_box_min_z,
    output coord_t          m_box_max_x,
    output coord_t          m_box_max_y,
    output coord_t          m_box_max_z
);

    psbsd_bk_state_t state_reg, state_next;

    logic [AXIS_W-1:0] axis_reg;
    coord_t            d_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   op_reg;
    logic [SQ_W-1:0]   res_reg;
    logic [SQ_W-1:0]   bit_reg;
    logic              over_reg;
    logic              m_valid_reg;

    coord_t                   dist_reg;
    coord_t                   min_x_reg, min_y_reg, min_z_reg;
    coord_t                   max_x_reg, max_y_reg, max_z_reg;

    logic signed [COORD_W:0]   gap_a, gap_b, gap_m;
    coord_t                    d_next;
    logic [SQ_W:0]             acc_sum;
    logic [SQ_W-1:0]           root_try;
    logic                      root_ge;
    logic signed [COORD_W+1:0] dist_full;
    coord_t                    dist_next;
    logic [AXIS_W-1:0]         last_axis;
    logic                      axis_last;
    logic                      out_free;

    logic start, gap_en, mul_en, acc_en, root_en, fin_load;

    assign last_axis = head.planar ? AXIS_Y : AXIS_Z;
    assign axis_last = (axis_reg == last_axis);
    assign out_free  = !m_valid_reg || m_ready;

    // per-axis gap: max(center - max, min - center, 0)
    always_comb begin
        gap_a  = $signed({head.ctr[axis_reg][COORD_W-1], head.ctr[axis_reg]})
               - $signed({head.hi[axis_reg][COORD_W-1], head.hi[axis_reg]});
        gap_b  = $signed({head.lo[axis_reg][COORD_W-1], head.lo[axis_reg]})
               - $signed({head.ctr[axis_reg][COORD_W-1], head.ctr[axis_reg]});
        gap_m  = (gap_b > gap_a) ? gap_b : gap_a;
        d_next = gap_m[COORD_W] ? '0 : gap_m[COORD_W-1:0];
    end

    // sum of squares, carry flags a sum at or above 2^64
    assign acc_sum = {1'b0, op_reg} + {1'b0, sq_reg};

    // one bit of the integer square root per cycle
    assign root_try = res_reg + bit_reg;
    assign root_ge  = (op_reg >= root_try);

    // norm minus radius, saturated high
    always_comb begin
        dist_full = $signed({2'b00, res_reg[COORD_W-1:0]}) - $signed({3'b000, head.radius});
        dist_next = (over_reg || (dist_full > DIST_LIMIT)) ? DIST_SAT : dist_full[COORD_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_status.empty) state_next = BK_GAP;
            BK_GAP:  state_next = BK_MUL;
            BK_MUL:  state_next = BK_ACC;
            BK_ACC:  state_next = axis_last ? BK_ROOT : BK_GAP;
            BK_ROOT: if (bit_reg[0]) state_next = BK_FIN;
            BK_FIN:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        start    = 1'b0;
        gap_en   = 1'b0;
        mul_en   = 1'b0;
        acc_en   = 1'b0;
        root_en  = 1'b0;
        fin_load = 1'b0;
        unique case (state_reg)
            BK_IDLE: start    = !q_status.empty;
            BK_GAP:  gap_en   = 1'b1;
            BK_MUL:  mul_en   = 1'b1;
            BK_ACC:  acc_en   = 1'b1;
            BK_ROOT: root_en  = 1'b1;
            BK_FIN:  fin_load = out_free;
            default: start    = 1'b0;
        endcase
    end

    assign pop = fin_load;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            axis_reg <= AXIS_X;
            op_reg   <= '0;
            over_reg <= 1'b0;
        end
        if (gap_en) begin
            d_reg <= d_next;
        end
        if (mul_en) begin
            sq_reg <= d_reg * d_reg;
        end
        if (acc_en) begin
            op_reg   <= acc_sum[SQ_W-1:0];
            over_reg <= over_reg | acc_sum[SQ_W];
            axis_reg <= axis_reg + 1'b1;
            if (axis_last) begin
                res_reg <= '0;
                bit_reg <= ROOT_BIT_INIT;
            end
        end
        if (root_en) begin
            if (root_ge) begin
                op_reg  <= op_reg - root_try;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (fin_load) begin
            dist_reg  <= dist_next;
            min_x_reg <= head.lo[AXIS_X];
            min_y_reg <= head.lo[AXIS_Y];
            min_z_reg <= head.planar ? '0 : head.lo[AXIS_Z];
            max_x_reg <= head.hi[AXIS_X];
            max_y_reg <= head.hi[AXIS_Y];
            max_z_reg <= head.planar ? '0 : head.hi[AXIS_Z];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_distance  = dist_reg;
    assign m_box_min_x = min_x_reg;
    assign m_box_min_y = min_y_reg;
    assign m_box_min_z = min_z_reg;
    assign m_box_max_x = max_x_reg;
    assign m_box_max_y = max_y_reg;
    assign m_box_max_z = max_z_reg;

endmodule

/* design/point_set_box_sphere_distance.sv */
// Channel   Direction  Handshake         Request contents
// s_*       in         s_valid/s_ready   point, sphere center, radius, last flag
// m_*       out        m_valid/m_ready   distance, box min and max corners
// cfg_*     in         cfg_wr_en         dimensions register (2 = planar)
//
// Points are taken one per cycle while the set queue has room; the box is updated as each point is taken.
// In the back end, each axis of a set passes through gap, multiply and accumulate
// steps on one 32x32 multiplier (x and y only in planar mode), then 32 root iterations.
// Finished sets wait in a small queue; s_ready drops only when it is full.
// Reset is synchronous, active low; it clears the set, the queue and m_valid.
module point_set_box_sphere_distance
    import psbsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  coord_t              s_point_x,
    input  coord_t              s_point_y,
    input  coord_t              s_point_z,
    input  coord_t              s_center_x,
    input  coord_t              s_center_y,
    input  coord_t              s_center_z,
    input  logic [RADIUS_W-1:0] s_radius,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output coord_t              m_distance,
    output coord_t              m_box_min_x,
    output coord_t              m_box_min_y,
    output coord_t              m_box_min_z,
    output coord_t              m_box_max_x,
    output coord_t              m_box_max_y,
    output coord_t              m_box_max_z,
    input  logic                cfg_wr_en,
    input  logic [DIMS_W-1:0]   cfg_wr_data
);

    psbsd_q_status_t q_status;
    psbsd_job_t      push_job;
    psbsd_job_t      head;
    logic            push;
    logic            pop;

    psbsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_point_z   (s_point_z),
        .s_center_x  (s_center_x),
        .s_center_y  (s_center_y),
        .s_center_z  (s_center_z),
        .s_radius    (s_radius),
        .s_last      (s_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    psbsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    psbsd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_box_min_x (m_box_min_x),
        .m_box_min_y (m_box_min_y),
        .m_box_min_z (m_box_min_z),
        .m_box_max_x (m_box_max_x),
        .m_box_max_y (m_box_max_y),
        .m_box_max_z (m_box_max_z)
    );

endmodule

/* design/psbsd_checker.sv */
`include "point_set_box_sphere_distance_defines.svh"

module psbsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_distance,
    input logic [31:0] m_box_min_x,
    input logic [31:0] m_box_min_y,
    input logic [31:0] m_box_min_z,
    input logic [31:0] m_box_max_x,
    input logic [31:0] m_box_max_y,
    input logic [31:0] m_box_max_z
);

    // reset empties the output register
    `PSBSD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    // a stalled result holds
    `PSBSD_ASSERT_RUN(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_distance) && $stable(m_box_min_x) && $stable(m_box_max_z), "result changed under stall")

    // every given box is ordered on each axis
    `PSBSD_ASSERT_RUN(a_box_order, aclk, aresetn, m_valid |-> ($signed(m_box_min_x) <= $signed(m_box_max_x)) && ($signed(m_box_min_y) <= $signed(m_box_max_y)) && ($signed(m_box_min_z) <= $signed(m_box_max_z)), "box min above max")

    // remaining box fields held under stall
    `PSBSD_ASSERT_RUN(a_box_hold, aclk, aresetn, m_valid && !m_ready |=> $stable(m_box_min_y) && $stable(m_box_min_z) && $stable(m_box_max_x) && $stable(m_box_max_y), "box changed under stall")

endmodule

bind point_set_box_sphere_distance psbsd_checker u_checker (.*);

/* bench/point_set_box_sphere_distance_tb.sv */
`timescale 1ns / 1ps

module point_set_box_sphere_distance_tb;
    import psbsd_pkg::*;

    localparam coord_t COORD_MIN = 32'h8000_0000;
    localparam coord_t COORD_MAX = 32'h7FFF_FFFF;
    localparam coord_t ONE       = 32'h0001_0000;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = 31'h7FFF_FFFF;
    // values other than planar select 3-D as well
    localparam logic [DIMS_W-1:0] DIMS_SPATIAL_0 = 2'd0;
    localparam logic [DIMS_W-1:0] DIMS_SPATIAL_1 = 2'd1;
    // wait after draining, with margin for the back end and the queue
    localparam int SETTLE_CYCLES = 128;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_POINTS  = 170;

    typedef struct {
        coord_t              px;
        coord_t              py;
        coord_t              pz;
        coord_t              cx;
        coord_t              cy;
        coord_t              cz;
        logic [RADIUS_W-1:0] radius;
        logic                last;
    } point_req_t;

    typedef struct {
        coord_t distance;
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_distance_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    coord_t              s_point_x;
    coord_t              s_point_y;
    coord_t              s_point_z;
    coord_t              s_center_x;
    coord_t              s_center_y;
    coord_t              s_center_z;
    logic [RADIUS_W-1:0] s_radius;
    logic                s_last;
    logic                m_valid;
    logic                m_ready;
    coord_t              m_distance;
    coord_t              m_box_min_x;
    coord_t              m_box_min_y;
    coord_t              m_box_min_z;
    coord_t              m_box_max_x;
    coord_t              m_box_max_y;
    coord_t              m_box_max_z;
    logic                cfg_wr_en;
    logic [DIMS_W-1:0]   cfg_wr_data;

    // shadow of the block: running box, empty flag and mode register
    logic signed [COORD_W-1:0] box_lo [AXES];
    logic signed [COORD_W-1:0] box_hi [AXES];
    bit                        box_empty;
    logic [DIMS_W-1:0]         dims_shadow;

    box_distance_t pending_results [$];
    box_distance_t oldest;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int requests_sent;
    int sets_sent;
    int results_checked;

    point_set_box_sphere_distance i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_point_z   (s_point_z),
        .s_center_x  (s_center_x),
        .s_center_y  (s_center_y),
        .s_center_z  (s_center_z),
        .s_radius    (s_radius),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_box_min_x (m_box_min_x),
        .m_box_min_y (m_box_min_y),
        .m_box_min_z (m_box_min_z),
        .m_box_max_x (m_box_max_x),
        .m_box_max_y (m_box_max_y),
        .m_box_max_z (m_box_max_z),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // box update per point; on the last point, gap norm minus radius
    task automatic predict_box_distance(input point_req_t r);
        logic signed [COORD_W-1:0] p [AXES];
        logic signed [COORD_W-1:0] c [AXES];
        logic signed [COORD_W+1:0] gap;
        logic signed [COORD_W+1:0] alt;
        logic signed [COORD_W+1:0] dist_val;
        logic [COORD_W-1:0]        mag;
        logic [SQ_W+1:0]           sum;
        logic [SQ_W-1:0]           trial_sq;
        logic [COORD_W-1:0]        root;
        logic [COORD_W-1:0]        trial;
        box_distance_t             res;
        int                        naxes;
        int                        i;
        p[AXIS_X] = r.px;
        p[AXIS_Y] = r.py;
        p[AXIS_Z] = r.pz;
        c[AXIS_X] = r.cx;
        c[AXIS_Y] = r.cy;
        c[AXIS_Z] = r.cz;
        for (i = 0; i < AXES; i++) begin
            if (box_empty || p[i] < box_lo[i]) box_lo[i] = p[i];
            if (box_empty || p[i] > box_hi[i]) box_hi[i] = p[i];
        end
        box_empty = 1'b0;
        if (!r.last) return;

        naxes = (dims_shadow == DIMS_PLANAR) ? 2 : 3;
        sum = '0;
        for (i = 0; i < naxes; i++) begin
            gap = c[i] - box_hi[i];
            alt = box_lo[i] - c[i];
            if (alt > gap) gap = alt;
            if (gap < 0) gap = 0;
            mag = gap[COORD_W-1:0];
            sum = sum + ({32'b0, mag} * {32'b0, mag});
        end

        if (sum[SQ_W+1:SQ_W] != 2'b00) begin
            // sum of squares at or above 2^64: norm too big for the format
            dist_val = {2'b00, DIST_SAT};
        end else begin
            root = '0;
            for (i = COORD_W - 1; i >= 0; i--) begin
                trial    = root | (32'd1 << i);
                trial_sq = {32'b0, trial} * {32'b0, trial};
                if (trial_sq <= sum[SQ_W-1:0]) root = trial;
            end
            dist_val = $signed({2'b00, root}) - $signed({3'b000, r.radius});
            if (dist_val > DIST_LIMIT) dist_val = DIST_LIMIT;
        end

        res.distance = dist_val[COORD_W-1:0];
        res.min_x    = box_lo[AXIS_X];
        res.min_y    = box_lo[AXIS_Y];
        res.min_z    = (naxes == 2) ? '0 : box_lo[AXIS_Z];
        res.max_x    = box_hi[AXIS_X];
        res.max_y    = box_hi[AXIS_Y];
        res.max_z    = (naxes == 2) ? '0 : box_hi[AXIS_Z];
        pending_results = {pending_results, res};
        box_empty = 1'b1;
        sets_sent++;
    endtask

    task automatic report_mismatch(input string field, input coord_t got, input coord_t want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: %s got %h expected %h", $realtime, field, got, want);
    endtask

    // result checker: each accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending, distance", m_distance, '0);
            end else begin
                oldest = pending_results.pop_front();
                results_checked++;
                if (m_distance !== oldest.distance)
                    report_mismatch("distance", m_distance, oldest.distance);
                if (m_box_min_x !== oldest.min_x)
                    report_mismatch("box_min_x", m_box_min_x, oldest.min_x);
                if (m_box_min_y !== oldest.min_y)
                    report_mismatch("box_min_y", m_box_min_y, oldest.min_y);
                if (m_box_min_z !== oldest.min_z)
                    report_mismatch("box_min_z", m_box_min_z, oldest.min_z);
                if (m_box_max_x !== oldest.max_x)
                    report_mismatch("box_max_x", m_box_max_x, oldest.max_x);
                if (m_box_max_y !== oldest.max_y)
                    report_mismatch("box_max_y", m_box_max_y, oldest.max_y);
                if (m_box_max_z !== oldest.max_z)
                    report_mismatch("box_max_z", m_box_max_z, oldest.max_z);
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: too long without any handshake on either channel
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("point_set_box_sphere_distance regression: fail");
        $finish;
    end

    function automatic point_req_t make_req(input coord_t px, input coord_t py, input coord_t pz,
                                            input coord_t cx, input coord_t cy, input coord_t cz,
                                            input logic [RADIUS_W-1:0] radius, input logic last);
        point_req_t r;
        r.px = px;
        r.py = py;
        r.pz = pz;
        r.cx = cx;
        r.cy = cy;
        r.cz = cz;
        r.radius = radius;
        r.last = last;
        return r;
    endfunction

    // one request: optional gap, then hold valid until accepted
    task automatic send_point(input point_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_point_x  <= r.px;
        s_point_y  <= r.py;
        s_point_z  <= r.pz;
        s_center_x <= r.cx;
        s_center_y <= r.cy;
        s_center_z <= r.cz;
        s_radius   <= r.radius;
        s_last     <= r.last;
        do @(posedge aclk); while (!s_ready);
        predict_box_distance(r);
        requests_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // mode register is written only with the block quiet
    task automatic write_dimensions(input logic [DIMS_W-1:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dims_shadow = value;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3:    return $urandom();
            default: return coord_t'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
        endcase
    endfunction

    function automatic logic [RADIUS_W-1:0] rand_radius();
        case ($urandom_range(7))
            0:       return '0;
            1:       return RADIUS_MAX;
            2, 3:    return RADIUS_W'($urandom());
            default: return RADIUS_W'($urandom_range(0, 32'h003F_FFFF));
        endcase
    endfunction

    // default mode after reset, multi-point and single-point sets
    task automatic test_reset_mode();
        send_point(make_req(0, 0, 0, rand_coord(), rand_coord(), rand_coord(), rand_radius(), 0));
        send_point(make_req(2*ONE, 2*ONE, 2*ONE, 0, 0, 0, 0, 0));
        send_point(make_req(ONE, -ONE, 0, 5*ONE, 6*ONE, 8*ONE, ONE, 1));
        // first point of a set is the whole box; center on it
        send_point(make_req(3*ONE, -4*ONE, 7*ONE, 3*ONE, -4*ONE, 7*ONE, 0, 1));
    endtask

    // coordinate and radius extremes, saturation on huge gaps
    task automatic test_extremes();
        send_point(make_req(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0, 0));
        send_point(make_req(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, RADIUS_MAX, 1));
        send_point(make_req(COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX, 0, 1));
        send_point(make_req(COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX, 1));
        // one axis at full span: norm just below 2^32
        send_point(make_req(COORD_MIN, 0, 0, COORD_MAX, 0, 0, 0, 1));
        send_point(make_req(COORD_MIN, 0, 0, COORD_MAX, 0, 0, RADIUS_MAX, 1));
        send_point(make_req(0, 0, 0, 0, 0, 0, RADIUS_MAX, 1));
    endtask

    // floor of the square root
    task automatic test_root_rounding();
        send_point(make_req(0, 0, 0, 1, 1, 0, 0, 1));
        send_point(make_req(0, 0, 0, 3*ONE, 4*ONE, 0, 0, 1));
        send_point(make_req(0, 0, 0, -1, -1, -1, 1, 1));
        send_point(make_req(0, 0, 0, 2, 3, 6, 10, 1));
    endtask

    // 2-D mode: z gap ignored, z box fields zero
    task automatic test_planar();
        write_dimensions(DIMS_PLANAR);
        send_point(make_req(0, 0, COORD_MIN, 3*ONE, 4*ONE, COORD_MAX, 0, 1));
        send_point(make_req(COORD_MAX, COORD_MIN, 5, 0, 0, 0, 0, 0));
        send_point(make_req(COORD_MIN, COORD_MAX, -5, 0, 0, COORD_MAX, 0, 1));
    endtask

    // mode taken from the last point, not the first
    task automatic test_mode_change_in_set();
        send_point(make_req(0, 0, 0, 0, 0, 0, 0, 0));
        send_point(make_req(ONE, ONE, ONE, 0, 0, 0, 0, 0));
        write_dimensions(DIMS_SPATIAL_0);
        send_point(make_req(0, 0, 0, 0, 0, 10*ONE, 0, 1));
        send_point(make_req(0, 0, 0, 0, 0, 0, 0, 0));
        write_dimensions(DIMS_PLANAR);
        send_point(make_req(0, 0, 0, 0, 0, 10*ONE, 0, 1));
    endtask

    // random sets: mostly short, a few long
    task automatic test_random_sets(input logic [DIMS_W-1:0] dims, input int send_pct,
                                    input int recv_pct);
        int points;
        int set_len;
        int k;
        int phase_sets;
        write_dimensions(dims);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        points = 0;
        phase_sets = 0;
        while (points < PHASE_POINTS) begin
            set_len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            for (k = 0; k < set_len; k++) begin
                send_point(make_req(rand_coord(), rand_coord(), rand_coord(),
                                    rand_coord(), rand_coord(), rand_coord(),
                                    rand_radius(), k == set_len - 1));
                points++;
            end
            phase_sets++;
            // hold off the sender until the queue has emptied
            if (phase_sets == 3 || $urandom_range(19) == 0)
                wait_results_drained();
        end
    endtask

    initial begin
        s_valid     <= 1'b0;
        s_point_x   <= '0;
        s_point_y   <= '0;
        s_point_z   <= '0;
        s_center_x  <= '0;
        s_center_y  <= '0;
        s_center_z  <= '0;
        s_radius    <= '0;
        s_last      <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= DIMS_RESET;
        m_ready     <= 1'b0;
        aresetn     <= 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 30;
        mismatches = 0;
        requests_sent = 0;
        sets_sent = 0;
        results_checked = 0;
        box_empty = 1'b1;
        dims_shadow = DIMS_RESET;
        for (int i = 0; i < AXES; i++) begin
            box_lo[i] = '0;
            box_hi[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_mode();
        test_extremes();
        test_root_rounding();
        test_planar();
        test_mode_change_in_set();
        test_random_sets(DIMS_SPATIAL_1, 18, 72);
        test_random_sets(DIMS_PLANAR, 72, 18);
        test_random_sets(DIMS_RESET, 0, 0);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d points in %0d sets, checked %0d results",
                 requests_sent, sets_sent, results_checked);
        $display("covered all mode values, a mode change mid-set, extremes and saturation");
        if (mismatches == 0) begin
            $display("point_set_box_sphere_distance regression: pass");
        end else begin
            $display("point_set_box_sphere_distance regression: fail");
        end
        $finish;
    end

endmodule
